// ===== hdl/rotated_sdf_bilinear_palette_sampler_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the palette sampler
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ROTATED_SDF_BILINEAR_PALETTE_SAMPLER_DEFINES_SVH
`define ROTATED_SDF_BILINEAR_PALETTE_SAMPLER_DEFINES_SVH

// cond must never hold at a clock edge outside reset
`define RSBP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// ante implies cons at the same edge
`define RSBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rsbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsbp_pkg
// Shared constants, codes and channel word types of the palette sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package rsbp_pkg;

    // default geometry
    localparam int DEF_SCREEN_W   = 240;
    localparam int DEF_SCREEN_H   = 240;
    localparam int DEF_FIELD_LOG2 = 7;
    localparam int DEF_DIST_SCALE = 4;

    // fixed field widths
    localparam int STEP_W    = 18;
    localparam int FRAC_W    = 12;
    localparam int LERP_W    = 8;
    localparam int FRAC_LSB  = FRAC_W - LERP_W;
    localparam int TEXEL_W   = 8;
    localparam int COLOUR_W  = 16;
    localparam int ADDR_W    = 14;
    localparam int DATA_W    = 16;
    localparam int PIX_W     = 8;
    localparam int PAL_AW    = 8;
    localparam int PAL_DEPTH = 1 << PAL_AW;
    localparam int SAT_MAX   = 255;
    localparam int DIST_CAP  = SAT_MAX + 1;

    localparam logic signed [STEP_W-1:0] COS_STEP_RESET = 18'sd4096;

    // request codes
    localparam logic [1:0] REQ_LOAD_FIELD   = 2'd0;
    localparam logic [1:0] REQ_LOAD_PALETTE = 2'd1;
    localparam logic [1:0] REQ_RENDER       = 2'd2;

    typedef enum logic {
        REG_COS_STEP = 1'b0,
        REG_SIN_STEP = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] load_address;
        logic [DATA_W-1:0] load_data;
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
        logic              in_mask;
    } req_word_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] pixel_colour;
    } pix_word_t;

    typedef struct packed {
        cfg_reg_t                 reg_index;
        logic signed [STEP_W-1:0] reg_value;
    } cfg_word_t;

endpackage

`default_nettype wire

// ===== hdl/rsbp_stream_if.sv =====
// ----------------------------------------------------------------------------
// rsbp_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsbp_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rotated_sdf_bilinear_palette_sampler.sv =====
// ----------------------------------------------------------------------------
// rotated_sdf_bilinear_palette_sampler
// Rotozoom distance-field sampler: rotate/scale, bilinear or border
// extrapolation, palette lookup to RGB565.
// ----------------------------------------------------------------------------
//
//  channel | dir | word       | contents
//  --------+-----+------------+------------------------------------------
//  item    | in  | req_word_t | field load, palette load or pixel render
//  result  | out | pix_word_t | RGB565 colour, one per render word
//  cfg     | in  | cfg_word_t | cos_step / sin_step write, always ready
//
//  One word per clock sustained while result.ready holds; throughput is
//  set by the four field banks, each read once per pixel, and the single
//  palette port.
//  Loads give no result; they write the field at stage 5 and the palette
//  at stage 8, in order with the renders reading those stores.
//  Stalls ripple back stage by stage, so empty stages fill while the
//  result waits. Reset acts on the stage valids and the step registers only.
//
`default_nettype none
`include "rotated_sdf_bilinear_palette_sampler_defines.svh"

module rotated_sdf_bilinear_palette_sampler #(
    parameter int SCREEN_W   = rsbp_pkg::DEF_SCREEN_W,
    parameter int SCREEN_H   = rsbp_pkg::DEF_SCREEN_H,
    parameter int FIELD_LOG2 = rsbp_pkg::DEF_FIELD_LOG2,
    parameter int DIST_SCALE = rsbp_pkg::DEF_DIST_SCALE
) (
    input  logic          clk,
    input  logic          rst_n,
    rsbp_stream_if.sink   item,
    rsbp_stream_if.source result,
    rsbp_stream_if.sink   cfg
);
    import rsbp_pkg::*;

    localparam int NUM_STAGES = 8;
    localparam int FIELD_N    = 1 << FIELD_LOG2;
    localparam int FI_W       = 2 * FIELD_LOG2;
    localparam int AX_W       = (FI_W > ADDR_W) ? FI_W : ADDR_W;
    // field split in four banks by row and column parity
    localparam int BANK_AW    = 2 * (FIELD_LOG2 - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int SW_BITS    = $clog2(SCREEN_W);
    localparam int SH_BITS    = $clog2(SCREEN_H);
    localparam int SD_BITS    = (SW_BITS > SH_BITS) ? SW_BITS : SH_BITS;
    localparam int D_W        = ((SD_BITS > PIX_W) ? SD_BITS : PIX_W) + 1;
    localparam int P_W        = D_W + STEP_W;
    localparam int U_W        = P_W + 2;
    localparam int I_W        = U_W - FRAC_W;
    localparam int E_W        = TEXEL_W + 1;
    localparam int SC_W       = $clog2(DIST_SCALE + 1);
    localparam int SUM_W      = TEXEL_W + SC_W + 1;

    localparam logic signed [U_W-1:0] HALF_U = U_W'((FIELD_N / 2) * (1 << FRAC_W));

    typedef struct packed {
        logic                fld_we;
        logic                pal_we;
        logic                render;
        logic                mask;
        logic [1:0]          fld_bank;
        logic [BANK_AW-1:0]  fld_addr;
        logic [PAL_AW-1:0]   pal_addr;
        logic [DATA_W-1:0]   data;
    } carry_t;

    typedef struct packed {
        logic                  in_span;
        logic [FIELD_LOG2-1:0] pos;
        logic [E_W-1:0]        excess;
    } axis_t;

    // clamp one axis, distance past the border saturated at DIST_CAP
    function automatic axis_t map_axis(input logic signed [I_W-1:0] v);
        axis_t          r;
        logic [I_W-1:0] ex;
        r  = '0;
        ex = '0;
        if (v < 0)
        begin
            r.pos = '0;
            ex    = -v;
        end
        else if (v > $signed(I_W'(FIELD_N - 1)))
        begin
            r.pos = '1;
            ex    = v - I_W'(FIELD_N - 1);
        end
        else
        begin
            r.pos = v[FIELD_LOG2-1:0];
        end
        r.in_span = (v >= 0) && (v < $signed(I_W'(FIELD_N - 1)));
        r.excess  = (ex > I_W'(DIST_CAP)) ? E_W'(DIST_CAP) : ex[E_W-1:0];
        return r;
    endfunction

    // a + floor((b - a) * f / 256)
    function automatic logic [TEXEL_W-1:0] lerp8(
        input logic [TEXEL_W-1:0] a,
        input logic [TEXEL_W-1:0] b,
        input logic [LERP_W-1:0]  f
    );
        logic signed [TEXEL_W:0]              diff;
        logic signed [TEXEL_W+LERP_W+1:0]     prod;
        logic signed [TEXEL_W:0]              step;
        diff  = $signed({1'b0, b}) - $signed({1'b0, a});
        prod  = diff * $signed({1'b0, f});
        step  = prod[TEXEL_W+LERP_W:LERP_W];
        return TEXEL_W'({1'b0, a} + step);
    endfunction

    // ---------------- configuration ----------------
    logic signed [STEP_W-1:0] cos_step_reg;
    logic signed [STEP_W-1:0] sin_step_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_step_reg <= COS_STEP_RESET;
            sin_step_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.reg_index)
                REG_COS_STEP: cos_step_reg <= cfg.data.reg_value;
                REG_SIN_STEP: sin_step_reg <= cfg.data.reg_value;
            endcase
        end
    end

    // ---------------- stage control ----------------
    logic [NUM_STAGES:1] stage_valid_reg;
    logic [NUM_STAGES:1] stage_valid_next;
    logic [NUM_STAGES:1] stage_en;
    carry_t              carry_reg [1:NUM_STAGES-1];
    carry_t              carry_next;

    // a stage loads when it is empty or its word moves on
    always_comb
    begin
        stage_en[NUM_STAGES] = !stage_valid_reg[NUM_STAGES] || result.ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            stage_en[k] = !stage_valid_reg[k] || stage_en[k+1];
        end
    end

    assign item.ready = stage_en[1];

    // ---------------- stage 1: decode ----------------
    logic [AX_W-1:0]       addr_wide;
    logic [FI_W-1:0]       fld_idx;
    logic signed [D_W-1:0] s1_dx_reg;
    logic signed [D_W-1:0] s1_dy_reg;

    assign addr_wide = AX_W'(item.data.load_address);
    assign fld_idx   = addr_wide[FI_W-1:0];

    always_comb
    begin
        carry_next          = '0;
        carry_next.mask     = item.data.in_mask;
        carry_next.fld_bank = {fld_idx[FIELD_LOG2], fld_idx[0]};
        carry_next.fld_addr = {fld_idx[FI_W-1:FIELD_LOG2+1], fld_idx[FIELD_LOG2-1:1]};
        carry_next.pal_addr = item.data.load_address[PAL_AW-1:0];
        carry_next.data     = item.data.load_data;
        unique case (item.data.req_type)
            REQ_LOAD_FIELD:   carry_next.fld_we = ((addr_wide >> FI_W) == '0);
            REQ_LOAD_PALETTE: carry_next.pal_we =
                (item.data.load_address[ADDR_W-1:PAL_AW] == '0);
            REQ_RENDER:       carry_next.render = 1'b1;
            default:          ;
        endcase
    end

    always_comb
    begin
        // dropped words (unused code, address out of range) vanish here
        stage_valid_next[1] = item.valid &&
            (carry_next.fld_we || carry_next.pal_we || carry_next.render);
        for (int k = 2; k < NUM_STAGES; k++)
        begin
            stage_valid_next[k] = stage_valid_reg[k-1];
        end
        // only renders reach the output stage
        stage_valid_next[NUM_STAGES] = stage_valid_reg[NUM_STAGES-1] &&
            carry_reg[NUM_STAGES-1].render;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    stage_valid_reg[k] <= stage_valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            carry_reg[1] <= carry_next;
            s1_dx_reg    <= $signed(D_W'(item.data.pixel_x)) - $signed(D_W'(SCREEN_W / 2));
            s1_dy_reg    <= $signed(D_W'(item.data.pixel_y)) - $signed(D_W'(SCREEN_H / 2));
        end
        for (int k = 2; k < NUM_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                carry_reg[k] <= carry_reg[k-1];
            end
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [P_W-1:0] s2_ucos_reg;
    logic signed [P_W-1:0] s2_usin_reg;
    logic signed [P_W-1:0] s2_wsin_reg;
    logic signed [P_W-1:0] s2_wcos_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s2_ucos_reg <= s1_dx_reg * cos_step_reg;
            s2_usin_reg <= s1_dy_reg * sin_step_reg;
            s2_wsin_reg <= s1_dx_reg * sin_step_reg;
            s2_wcos_reg <= s1_dy_reg * cos_step_reg;
        end
    end

    // ---------------- stage 3: field coordinates, Q12 ----------------
    logic signed [U_W-1:0] s3_u_reg;
    logic signed [U_W-1:0] s3_w_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s3_u_reg <= U_W'(s2_ucos_reg) - U_W'(s2_usin_reg) + HALF_U;
            s3_w_reg <= U_W'(s2_wsin_reg) + U_W'(s2_wcos_reg) + HALF_U;
        end
    end

    // ---------------- stage 4: clamp, range, fractions ----------------
    axis_t                 axis_u;
    axis_t                 axis_w;
    logic [FIELD_LOG2-1:0] s4_x0_reg;
    logic [FIELD_LOG2-1:0] s4_y0_reg;
    logic [LERP_W-1:0]     s4_fu_reg;
    logic [LERP_W-1:0]     s4_fw_reg;
    logic [E_W-1:0]        s4_eu_reg;
    logic [E_W-1:0]        s4_ew_reg;
    logic                  s4_oob_reg;

    // floor by arithmetic shift: the upper bits are the integer part
    assign axis_u = map_axis($signed(s3_u_reg[U_W-1:FRAC_W]));
    assign axis_w = map_axis($signed(s3_w_reg[U_W-1:FRAC_W]));

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s4_x0_reg  <= axis_u.pos;
            s4_y0_reg  <= axis_w.pos;
            s4_fu_reg  <= s3_u_reg[FRAC_W-1:FRAC_LSB];
            s4_fw_reg  <= s3_w_reg[FRAC_W-1:FRAC_LSB];
            s4_eu_reg  <= axis_u.excess;
            s4_ew_reg  <= axis_w.excess;
            s4_oob_reg <= !(axis_u.in_span && axis_w.in_span);
        end
    end

    // ---------------- stage 5: field banks ----------------
    // each of the four bilinear taps lands in a different bank
    logic                      fld_wr;
    logic                      fld_rd;
    logic [3:0][TEXEL_W-1:0]   bank_q;
    logic                      s5_x0p_reg;
    logic                      s5_y0p_reg;
    logic [LERP_W-1:0]         s5_fu_reg;
    logic [LERP_W-1:0]         s5_fw_reg;
    logic [E_W-1:0]            s5_dist_reg;
    logic                      s5_oob_reg;

    assign fld_wr = stage_en[5] && stage_valid_reg[4] && carry_reg[4].fld_we;
    assign fld_rd = stage_en[5] && stage_valid_reg[4] && carry_reg[4].render;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(b);
        logic [TEXEL_W-1:0]    mem [BANK_DEPTH];
        logic [TEXEL_W-1:0]    q_reg;
        logic [FIELD_LOG2-1:0] col;
        logic [FIELD_LOG2-1:0] row;
        logic [BANK_AW-1:0]    rd_addr;

        assign col = (BANK_ID[0] == s4_x0_reg[0]) ? s4_x0_reg :
                     s4_x0_reg + FIELD_LOG2'(1);
        assign row = (BANK_ID[1] == s4_y0_reg[0]) ? s4_y0_reg :
                     s4_y0_reg + FIELD_LOG2'(1);
        assign rd_addr = {row[FIELD_LOG2-1:1], col[FIELD_LOG2-1:1]};

        always_ff @(posedge clk)
        begin
            if (fld_wr && carry_reg[4].fld_bank == BANK_ID)
            begin
                mem[carry_reg[4].fld_addr] <= carry_reg[4].data[TEXEL_W-1:0];
            end
            if (fld_rd)
            begin
                q_reg <= mem[rd_addr];
            end
        end

        assign bank_q[b] = q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            s5_x0p_reg  <= s4_x0_reg[0];
            s5_y0p_reg  <= s4_y0_reg[0];
            s5_fu_reg   <= s4_fu_reg;
            s5_fw_reg   <= s4_fw_reg;
            s5_dist_reg <= (s4_eu_reg > s4_ew_reg) ? s4_eu_reg : s4_ew_reg;
            s5_oob_reg  <= s4_oob_reg;
        end
    end

    // ---------------- stage 6: horizontal lerps, border index ----------------
    logic [TEXEL_W-1:0] tap_a;
    logic [TEXEL_W-1:0] tap_b;
    logic [TEXEL_W-1:0] tap_c;
    logic [TEXEL_W-1:0] tap_d;
    logic [SUM_W-1:0]   border_sum;
    logic [TEXEL_W-1:0] s6_top_reg;
    logic [TEXEL_W-1:0] s6_bot_reg;
    logic [LERP_W-1:0]  s6_fw_reg;
    logic               s6_oob_reg;
    logic [PAL_AW-1:0]  s6_oob_idx_reg;

    assign tap_a = bank_q[{s5_y0p_reg, s5_x0p_reg}];
    assign tap_b = bank_q[{s5_y0p_reg, !s5_x0p_reg}];
    assign tap_c = bank_q[{!s5_y0p_reg, s5_x0p_reg}];
    assign tap_d = bank_q[{!s5_y0p_reg, !s5_x0p_reg}];

    // clamped texel (tap a) plus scaled distance past the border
    assign border_sum = SUM_W'(tap_a) +
        SUM_W'(s5_dist_reg[TEXEL_W-1:0]) * SUM_W'(DIST_SCALE);

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            s6_top_reg     <= lerp8(tap_a, tap_b, s5_fu_reg);
            s6_bot_reg     <= lerp8(tap_c, tap_d, s5_fu_reg);
            s6_fw_reg      <= s5_fw_reg;
            s6_oob_reg     <= s5_oob_reg;
            s6_oob_idx_reg <= (s5_dist_reg > E_W'(SAT_MAX) ||
                               border_sum > SUM_W'(SAT_MAX)) ?
                              PAL_AW'(SAT_MAX) : border_sum[PAL_AW-1:0];
        end
    end

    // ---------------- stage 7: vertical lerp or border index ----------------
    logic [PAL_AW-1:0] s7_idx_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            s7_idx_reg <= s6_oob_reg ? s6_oob_idx_reg :
                          lerp8(s6_top_reg, s6_bot_reg, s6_fw_reg);
        end
    end

    // ---------------- stage 8: palette, output ----------------
    logic [COLOUR_W-1:0] pal_mem [PAL_DEPTH];
    logic [COLOUR_W-1:0] pal_q_reg;
    logic                s8_mask_reg;
    logic                pal_wr;
    logic                pal_rd;

    assign pal_wr = stage_en[8] && stage_valid_reg[7] && carry_reg[7].pal_we;
    assign pal_rd = stage_en[8] && stage_valid_reg[7] && carry_reg[7].render;

    always_ff @(posedge clk)
    begin
        if (pal_wr)
        begin
            pal_mem[carry_reg[7].pal_addr] <= carry_reg[7].data;
        end
        if (pal_rd)
        begin
            pal_q_reg <= pal_mem[s7_idx_reg];
        end
        if (stage_en[8])
        begin
            s8_mask_reg <= carry_reg[7].mask;
        end
    end

    assign result.valid             = stage_valid_reg[NUM_STAGES];
    assign result.data.pixel_colour = s8_mask_reg ? pal_q_reg : '0;

    // ---------------- checks ----------------
    `RSBP_ASSERT_NEVER(a_fld_port, clk, rst_n, fld_wr && fld_rd, "field bank read and write together")
    `RSBP_ASSERT_NEVER(a_pal_port, clk, rst_n, pal_wr && pal_rd, "palette read and write together")
    `RSBP_ASSERT_IMPLY(a_full_stall, clk, rst_n, !item.ready, &stage_valid_reg, "input held with a bubble")

endmodule

`default_nettype wire
